// ----- rtl/core/kmdr_pkg.sv -----
// ----------------------------------------------------------------------------
// kmdr_pkg
// Shared types and constants for the key matrix debounce and repeat block.
// ----------------------------------------------------------------------------
package kmdr_pkg;

  // Matrix geometry
  localparam int unsigned ROWS  = 4;
  localparam int unsigned COLS  = 4;
  localparam int unsigned NKEYS = ROWS * COLS;
  localparam int unsigned KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;

  // Field widths fixed by the interface
  localparam int unsigned ROW_W   = 2;
  localparam int unsigned COL_W   = 2;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned KIDX_W  = 4;
  localparam int unsigned CIDX_W  = 3;
  localparam int unsigned CDATA_W = 16;

  // Event codes
  localparam logic [KIND_W-1:0] EV_PRESS   = 2'd0;
  localparam logic [KIND_W-1:0] EV_REPEAT  = 2'd1;
  localparam logic [KIND_W-1:0] EV_RELEASE = 2'd2;

  // Register indexes
  localparam logic [CIDX_W-1:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [CIDX_W-1:0] REG_REPEAT      = 3'd1;
  localparam logic [CIDX_W-1:0] REG_PRESS_EN    = 3'd2;
  localparam logic [CIDX_W-1:0] REG_RELEASE_EN  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_REPEAT_EN   = 3'd4;

  // Event queue sizing: one request makes at most MAX_EV events
  localparam int unsigned MAX_EV     = 2;
  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

  // One queued event
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KIDX_W-1:0] key;
    logic              last;
  } event_t;

  // Per-key timestamps kept in the memory
  typedef struct packed {
    logic [TIME_W-1:0] first_seen;
    logic [TIME_W-1:0] last_repeat;
  } key_times_t;

endpackage

// ----- rtl/core/key_matrix_debounce_repeat.sv -----
// ----------------------------------------------------------------------------
// key_matrix_debounce_repeat
// Per-key debounce, auto-repeat and release detection for a scanned matrix.
// ----------------------------------------------------------------------------
// Usage:
//   Each input request is one key sample (row, column, closed flag, ms time).
//   Each output request is one event (press, repeat or release) with its key
//   index; last marks the final event caused by a sample (zero to two).
//   Registers must be written by the user through the cfg channel only while
//   the block is idle; the block does not enforce this. cfg_ready is always high.
// Timing:
//   A sample is accepted, its key entry is read from the timestamp memory,
//   and in the next cycle the entry is updated and its events are queued.
//   One sample per cycle is taken; the rate is set by the eight-entry event
//   queue, which must keep room for two events of the sample in flight and
//   two of a new one. A write followed by a read of the same key is
//   forwarded around the memory.
// Reset:
//   Clears registers, key flags, valid bits of the memory and the queue.
//   When the receiver stalls, the queue fills and in_ready drops.
// ----------------------------------------------------------------------------
module key_matrix_debounce_repeat (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [kmdr_pkg::ROW_W-1:0]    in_row_sel,
  input  logic [kmdr_pkg::COL_W-1:0]    in_col_sel,
  input  logic                          in_is_down,
  input  logic [kmdr_pkg::TIME_W-1:0]   in_now_ms,
  // event channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [kmdr_pkg::KIND_W-1:0]   out_event_kind,
  output logic [kmdr_pkg::KIDX_W-1:0]   out_key_index,
  output logic                          out_last,
  // configuration channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kmdr_pkg::CIDX_W-1:0]   cfg_index,
  input  logic [kmdr_pkg::CDATA_W-1:0]  cfg_data
);
  import kmdr_pkg::*;

  // Configuration registers
  logic [MS_W-1:0] debounce_r;
  logic [MS_W-1:0] repeat_r;
  logic            press_en_r;
  logic            release_en_r;
  logic            repeat_en_r;

  // Per-key flags and memory valid bits
  logic [NKEYS-1:0] seen_r;
  logic [NKEYS-1:0] conf_r;
  logic [NKEYS-1:0] tvld_r;

  // Timestamp memory and its read register
  key_times_t time_mem [NKEYS];
  key_times_t rd_data_r;

  // Update stage
  logic              s1_vld_r;
  logic              s1_in_range_r;
  logic [KEY_W-1:0]  s1_key_r;
  logic              s1_down_r;
  logic [TIME_W-1:0] s1_now_r;

  // Forwarding of the last write
  logic              wr_vld_r;
  logic [KEY_W-1:0]  wr_key_r;
  key_times_t        wr_data_r;

  // Event queue
  event_t            fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;

  logic              in_acc;
  logic              out_acc;
  logic [KEY_W-1:0]  in_key;
  logic              in_range;

  key_times_t        cur_times;
  key_times_t        new_times;
  logic              cur_seen;
  logic              cur_conf;
  logic              new_seen;
  logic              new_conf;
  logic [TIME_W-1:0] dt_first;
  logic [TIME_W-1:0] dt_repeat;
  logic              do_press;
  logic              do_repeat;
  logic              do_release;
  logic              confirm;
  event_t            ev0;
  event_t            ev1;
  logic [1:0]        push_n;
  logic              upd;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;

  // Take a sample only if the queue has room for the one in flight and this one
  always_comb begin
    if (s1_vld_r) begin
      in_ready = (cnt_r <= CNT_W'(FIFO_DEPTH - 2 * MAX_EV));
    end else begin
      in_ready = (cnt_r <= CNT_W'(FIFO_DEPTH - MAX_EV));
    end
  end

  // Key index of the incoming sample
  assign in_range = (32'(in_row_sel) < ROWS) && (32'(in_col_sel) < COLS);
  assign in_key   = KEY_W'(32'(in_row_sel) * COLS + 32'(in_col_sel));

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= '0;
      repeat_r     <= '0;
      press_en_r   <= 1'b0;
      release_en_r <= 1'b0;
      repeat_en_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   debounce_r   <= cfg_data[MS_W-1:0];
        REG_REPEAT:     repeat_r     <= cfg_data[MS_W-1:0];
        REG_PRESS_EN:   press_en_r   <= cfg_data[0];
        REG_RELEASE_EN: release_en_r <= cfg_data[0];
        REG_REPEAT_EN:  repeat_en_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Advance the sample into the update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_in_range_r <= in_range;
      s1_key_r      <= in_key;
      s1_down_r     <= in_is_down;
      s1_now_r      <= in_now_ms;
    end
  end

  // Read the key entry at acceptance
  always_ff @(posedge clk) begin
    if (in_acc) begin
      rd_data_r <= time_mem[in_key];
    end
  end

  // Select current timestamps: forwarded write, memory, or reset value
  always_comb begin
    if (wr_vld_r && (wr_key_r == s1_key_r)) begin
      cur_times = wr_data_r;
    end else if (tvld_r[s1_key_r]) begin
      cur_times = rd_data_r;
    end else begin
      cur_times = '0;
    end
  end

  assign cur_seen  = seen_r[s1_key_r];
  assign cur_conf  = conf_r[s1_key_r];
  assign dt_first  = s1_now_r - cur_times.first_seen;
  assign dt_repeat = s1_now_r - cur_times.last_repeat;

  // Debounce, repeat and release decisions
  always_comb begin
    new_times  = cur_times;
    new_seen   = cur_seen;
    new_conf   = cur_conf;
    confirm    = 1'b0;
    do_press   = 1'b0;
    do_repeat  = 1'b0;
    do_release = 1'b0;
    if (s1_down_r) begin
      if (cur_seen) begin
        confirm  = !cur_conf && (dt_first > TIME_W'(debounce_r));
        new_conf = cur_conf || confirm;
        do_press = confirm && press_en_r;
        do_repeat = repeat_en_r && new_conf && (dt_repeat > TIME_W'(repeat_r));
        if (do_repeat) begin
          new_times.last_repeat = s1_now_r;
        end
      end else begin
        new_seen              = 1'b1;
        new_conf              = 1'b0;
        new_times.first_seen  = s1_now_r;
      end
    end else begin
      do_release = cur_conf && release_en_r;
      new_conf   = 1'b0;
      new_seen   = 1'b0;
    end
  end

  assign upd = s1_vld_r && s1_in_range_r;

  // Pack events in order: press before repeat
  always_comb begin
    ev0      = '0;
    ev1      = '0;
    push_n   = 2'd0;
    ev0.key  = KIDX_W'(s1_key_r);
    ev1.key  = KIDX_W'(s1_key_r);
    ev1.kind = EV_REPEAT;
    ev1.last = 1'b1;
    if (upd) begin
      if (do_release) begin
        ev0.kind = EV_RELEASE;
        ev0.last = 1'b1;
        push_n   = 2'd1;
      end else if (do_press) begin
        ev0.kind = EV_PRESS;
        ev0.last = !do_repeat;
        push_n   = do_repeat ? 2'd2 : 2'd1;
      end else if (do_repeat) begin
        ev0.kind = EV_REPEAT;
        ev0.last = 1'b1;
        push_n   = 2'd1;
      end
    end
  end

  // Write back the key entry
  always_ff @(posedge clk) begin
    if (upd) begin
      time_mem[s1_key_r] <= new_times;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      wr_key_r  <= s1_key_r;
      wr_data_r <= new_times;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r   <= '0;
      conf_r   <= '0;
      tvld_r   <= '0;
      wr_vld_r <= 1'b0;
    end else begin
      wr_vld_r <= upd;
      if (upd) begin
        seen_r[s1_key_r] <= new_seen;
        conf_r[s1_key_r] <= new_conf;
        tvld_r[s1_key_r] <= 1'b1;
      end
    end
  end

  // Event queue: push up to two, pop one
  assign cnt_nxt = cnt_r + CNT_W'(push_n) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + PTR_W'(push_n);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_acc);
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      fifo_r[wr_ptr_r] <= ev0;
    end
    if (push_n == 2'd2) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= ev1;
    end
  end

  // Drive the head of the queue
  assign out_valid      = (cnt_r != '0);
  assign out_event_kind = fifo_r[rd_ptr_r].kind;
  assign out_key_index  = fifo_r[rd_ptr_r].key;
  assign out_last       = fifo_r[rd_ptr_r].last;

  // Checks
  a_fifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("event queue overflow");

  a_conf_needs_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (conf_r & ~seen_r) == '0)
    else $error("key confirmed without being seen closed");

  a_open_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && !s1_down_r) |=> (!seen_r[$past(s1_key_r)] && !conf_r[$past(s1_key_r)]))
    else $error("open sample did not clear key flags");

  a_release_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (upd && !s1_down_r) |-> (push_n != 2'd2))
    else $error("open sample produced more than one event");

endmodule

// ----- test/key_matrix_debounce_repeat_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_matrix_debounce_repeat_test
// Self-checking bench for the key matrix debounce and repeat block.
// Key samples go in through a queue-fed driver. A predictor keeps its own copy
// of the per-key flags, the timestamps and the registers, and works out the
// press, repeat and release events of each accepted sample. A monitor checks
// every event leaving the block against those expectations, in order.
// The run steps through several register settings, the extremes among them,
// with random pauses on both sides and one long output stall.
// ----------------------------------------------------------------------------
module key_matrix_debounce_repeat_test;
  import kmdr_pkg::*;

  localparam int unsigned CLK_PERIOD      = 20;
  localparam int unsigned RST_CYCLES      = 7;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned SETTLE_LIMIT    = 100000;
  localparam int unsigned ITEMS_PER_PHASE = 155;
  localparam int unsigned MAX_GAP         = 19;
  localparam int unsigned STALL_CYCLES    = 400;

  typedef enum int {IDLE_NONE, IDLE_SOME, IDLE_FULL} idle_mode_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic              down;
    logic [TIME_W-1:0] now;
  } sample_t;

  // DUT ports
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [ROW_W-1:0]    in_row_sel     = '0;
  logic [COL_W-1:0]    in_col_sel     = '0;
  logic                in_is_down     = 1'b0;
  logic [TIME_W-1:0]   in_now_ms      = '0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [KIND_W-1:0]   out_event_kind;
  logic [KIDX_W-1:0]   out_key_index;
  logic                out_last;
  logic                cfg_valid      = 1'b0;
  logic                cfg_ready;
  logic [CIDX_W-1:0]   cfg_index      = '0;
  logic [CDATA_W-1:0]  cfg_data       = '0;

  // Pending samples and expected events
  sample_t     scan_q[$];
  event_t      event_exp_q[$];

  // Predictor copy of the registers and the per-key state
  logic [MS_W-1:0]   dbnc_ms    = '0;
  logic [MS_W-1:0]   rpt_ms     = '0;
  logic              press_on   = 1'b0;
  logic              release_on = 1'b0;
  logic              repeat_on  = 1'b0;
  logic              key_seen [NKEYS];
  logic              key_held [NKEYS];
  logic [TIME_W-1:0] t_first  [NKEYS];
  logic [TIME_W-1:0] t_rpt    [NKEYS];

  // Physical switch level per key, used by the traffic generator
  logic              key_phys [NKEYS];

  // Handshake flags captured at the rising edge for the falling-edge drivers
  logic        in_took  = 1'b0;
  logic        out_took = 1'b0;

  idle_mode_t  tx_mode   = IDLE_NONE;
  idle_mode_t  rx_mode   = IDLE_NONE;
  int unsigned tx_wait   = 0;
  int unsigned rx_wait   = 0;
  int unsigned hold_req  = 0;
  int unsigned hold_left = 0;

  int unsigned err_cnt    = 0;
  int unsigned n_samples  = 0;
  int unsigned n_events   = 0;
  int unsigned n_settings = 0;
  int unsigned kind_cnt [3];

  key_matrix_debounce_repeat dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_row_sel     (in_row_sel),
    .in_col_sel     (in_col_sel),
    .in_is_down     (in_is_down),
    .in_now_ms      (in_now_ms),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_key_index  (out_key_index),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    clk = 1'b1;
    #(CLK_PERIOD / 2);
    clk = 1'b0;
    #(CLK_PERIOD / 2);
  end

  initial begin
    foreach (key_seen[i]) begin
      key_seen[i] = 1'b0;
      key_held[i] = 1'b0;
      t_first[i]  = '0;
      t_rpt[i]    = '0;
      key_phys[i] = 1'b0;
    end
    foreach (kind_cnt[i]) kind_cnt[i] = 0;
  end

  function automatic void note_error(input string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("ERROR: %s", msg);
  endfunction

  function automatic int unsigned draw_gap(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: return 0;
      IDLE_FULL: return $urandom_range(0, MAX_GAP);
      default:   return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
    endcase
  endfunction

  // Work out the events of one sample and advance the key state
  function automatic void predict_scan(input sample_t s);
    event_t            evs[$];
    event_t            ev;
    logic [KIDX_W-1:0] k;
    logic [TIME_W-1:0] dt;
    if (s.row >= ROWS || s.col >= COLS) return;
    k = KIDX_W'(s.row * COLS + s.col);
    ev.key  = k;
    ev.last = 1'b0;
    if (s.down) begin
      if (key_seen[k]) begin
        // confirm once the closure has lasted past the debounce time
        dt = s.now - t_first[k];
        if (!key_held[k] && dt > dbnc_ms) begin
          key_held[k] = 1'b1;
          if (press_on) begin
            ev.kind = EV_PRESS;
            evs.push_back(ev);
          end
        end
        dt = s.now - t_rpt[k];
        if (repeat_on && key_held[k] && dt > rpt_ms) begin
          ev.kind = EV_REPEAT;
          evs.push_back(ev);
          t_rpt[k] = s.now;
        end
      end else begin
        // first closed sample: record the time only
        key_seen[k] = 1'b1;
        t_first[k]  = s.now;
        key_held[k] = 1'b0;
      end
    end else begin
      if (key_held[k]) begin
        key_held[k] = 1'b0;
        if (release_on) begin
          ev.kind = EV_RELEASE;
          evs.push_back(ev);
        end
      end
      key_seen[k] = 1'b0;
    end
    if (evs.size() != 0) evs[evs.size() - 1].last = 1'b1;
    foreach (evs[i]) event_exp_q.push_back(evs[i]);
  endfunction

  // Check events, track register writes and predict accepted samples
  always @(posedge clk) begin : monitor
    event_t got;
    event_t want;
    out_took = rst_n && out_valid && out_ready;
    in_took  = rst_n && in_valid && in_ready;
    if (out_took) begin
      got.kind = out_event_kind;
      got.key  = out_key_index;
      got.last = out_last;
      if (event_exp_q.size() == 0) begin
        note_error($sformatf("unexpected event: kind %0d key %0d last %0d",
                             got.kind, got.key, got.last));
      end else begin
        want = event_exp_q.pop_front();
        if (got.kind !== want.kind || got.key !== want.key || got.last !== want.last)
          note_error($sformatf({"event %0d: expected kind %0d key %0d last %0d, ",
                                "got kind %0d key %0d last %0d"},
                               n_events, want.kind, want.key, want.last,
                               got.kind, got.key, got.last));
        else if (got.kind < 3)
          kind_cnt[got.kind]++;
      end
      n_events++;
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_DEBOUNCE:   dbnc_ms    = cfg_data;
        REG_REPEAT:     rpt_ms     = cfg_data;
        REG_PRESS_EN:   press_on   = cfg_data[0];
        REG_RELEASE_EN: release_on = cfg_data[0];
        REG_REPEAT_EN:  repeat_on  = cfg_data[0];
        default: ;
      endcase
    end
    if (in_took) begin
      predict_scan(scan_q.pop_front());
      n_samples++;
    end
  end

  // Offer pending samples; hold each request until it is taken
  always @(negedge clk) begin : drive_samples
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (in_took) tx_wait = draw_gap(tx_mode);
      if (tx_wait > 0) begin
        tx_wait--;
        in_valid <= 1'b0;
      end else if (scan_q.size() != 0) begin
        in_valid   <= 1'b1;
        in_row_sel <= scan_q[0].row;
        in_col_sel <= scan_q[0].col;
        in_is_down <= scan_q[0].down;
        in_now_ms  <= scan_q[0].now;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Pause the event side per request, plus one long stall on demand
  always @(negedge clk) begin : drive_ready
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (out_took) rx_wait = draw_gap(rx_mode);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_wait > 0) begin
        rx_wait--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_scan(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col,
                           input logic down, input logic [TIME_W-1:0] now);
    sample_t s;
    s.row  = row;
    s.col  = col;
    s.down = down;
    s.now  = now;
    scan_q.push_back(s);
  endtask

  // Write all five registers through the config channel
  task automatic set_regs(input logic [MS_W-1:0] dbnc, input logic [MS_W-1:0] rpt,
                          input logic pe, input logic rle, input logic rpe);
    logic [CIDX_W-1:0]  idx [5];
    logic [CDATA_W-1:0] val [5];
    int                 i;
    idx = '{REG_DEBOUNCE, REG_REPEAT, REG_PRESS_EN, REG_RELEASE_EN, REG_REPEAT_EN};
    val = '{dbnc, rpt, {15'd0, pe}, {15'd0, rle}, {15'd0, rpe}};
    for (i = 0; i < 5; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Wait for all samples and events to drain, then let the pipeline empty
  task automatic settle();
    int unsigned n;
    n = 0;
    while ((scan_q.size() != 0 || event_exp_q.size() != 0) && n < SETTLE_LIMIT) begin
      @(negedge clk);
      n++;
    end
    if (scan_q.size() != 0 || event_exp_q.size() != 0) begin
      note_error($sformatf("%0d samples not taken, %0d expected events missing",
                           scan_q.size(), event_exp_q.size()));
      event_exp_q.delete();
    end
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Mostly plausible press/hold/release traffic on a few keys, some noise
  task automatic gen_traffic(input int unsigned n, input int unsigned step_max,
                             input logic [TIME_W-1:0] t0);
    logic [TIME_W-1:0] t;
    logic [KIDX_W-1:0] focus [3];
    logic [KIDX_W-1:0] k;
    int unsigned       i;
    t = t0;
    foreach (focus[j]) focus[j] = KIDX_W'($urandom_range(0, NKEYS - 1));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: any key, any level, any time
        push_scan(ROW_W'($urandom_range(0, 3)), COL_W'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), $urandom());
      end else begin
        t += $urandom_range(0, step_max);
        k = ($urandom_range(0, 9) < 7) ? focus[$urandom_range(0, 2)]
                                       : KIDX_W'($urandom_range(0, NKEYS - 1));
        if ($urandom_range(0, 7) == 0) key_phys[k] = !key_phys[k];
        // occasional contact bounce flips one reading
        push_scan(k[3:2], k[1:0], key_phys[k] ^ ($urandom_range(0, 9) == 0), t);
      end
    end
  endtask

  task automatic run_phase(input logic [MS_W-1:0] dbnc, input logic [MS_W-1:0] rpt,
                           input logic pe, input logic rle, input logic rpe,
                           input idle_mode_t txm, input idle_mode_t rxm,
                           input logic [TIME_W-1:0] t0);
    int unsigned span;
    span    = (dbnc > rpt) ? dbnc : rpt;
    tx_mode = txm;
    rx_mode = rxm;
    set_regs(dbnc, rpt, pe, rle, rpe);
    gen_traffic(ITEMS_PER_PHASE, span / 3 + 2, t0);
    settle();
  endtask

  initial begin : stimulus
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: debounce edge, press with repeat, wraparound, bounce
    tx_mode = IDLE_FULL;
    rx_mode = IDLE_FULL;
    set_regs(16'd10, 16'd4, 1'b1, 1'b1, 1'b1);
    push_scan(2'd0, 2'd0, 1'b1, 32'd100);
    push_scan(2'd0, 2'd0, 1'b1, 32'd105);
    push_scan(2'd0, 2'd0, 1'b1, 32'd110);
    push_scan(2'd0, 2'd0, 1'b1, 32'd111);
    push_scan(2'd0, 2'd0, 1'b1, 32'd115);
    push_scan(2'd0, 2'd0, 1'b1, 32'd116);
    push_scan(2'd0, 2'd0, 1'b0, 32'd120);
    push_scan(2'd0, 2'd0, 1'b0, 32'd121);
    push_scan(2'd0, 2'd0, 1'b1, 32'd130);
    push_scan(2'd0, 2'd0, 1'b1, 32'd141);
    push_scan(2'd3, 2'd3, 1'b1, 32'hFFFF_FFF8);
    push_scan(2'd3, 2'd3, 1'b1, 32'h0000_0004);
    push_scan(2'd3, 2'd3, 1'b1, 32'h0000_0009);
    push_scan(2'd3, 2'd3, 1'b0, 32'h0000_000A);
    push_scan(2'd1, 2'd1, 1'b1, 32'd200);
    push_scan(2'd1, 2'd1, 1'b0, 32'd205);
    push_scan(2'd1, 2'd1, 1'b1, 32'd206);
    push_scan(2'd1, 2'd1, 1'b1, 32'd300);
    push_scan(2'd2, 2'd2, 1'b1, 32'hFFFF_FFFF);
    push_scan(2'd2, 2'd2, 1'b1, 32'h0000_0000);
    settle();

    // Directed: all events off, state must still move
    set_regs(16'd0, 16'd0, 1'b0, 1'b0, 1'b0);
    push_scan(2'd1, 2'd1, 1'b1, 32'd301);
    push_scan(2'd1, 2'd1, 1'b0, 32'd302);
    push_scan(2'd1, 2'd1, 1'b1, 32'd303);
    push_scan(2'd1, 2'd1, 1'b1, 32'd304);
    push_scan(2'd1, 2'd1, 1'b0, 32'd305);
    settle();

    // Random phases over low and high extremes and mixed enables
    run_phase(16'd0, 16'd0, 1'b1, 1'b1, 1'b1, IDLE_NONE, IDLE_NONE, 32'hFFFF_FFF0);
    run_phase(16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, IDLE_SOME, IDLE_FULL, 32'hFFFF_0000);
    run_phase(16'd20, 16'd7, 1'b0, 1'b1, 1'b1, IDLE_FULL, IDLE_SOME, $urandom());
    run_phase(16'd5, 16'd50, 1'b1, 1'b0, 1'b0, IDLE_SOME, IDLE_SOME, $urandom());

    // Stall the event side long enough to fill the block and block input
    hold_req = STALL_CYCLES;
    run_phase(16'd3, 16'd2, 1'b1, 1'b1, 1'b1, IDLE_NONE, IDLE_SOME, $urandom());

    run_phase(MS_W'($urandom_range(0, 40)), MS_W'($urandom_range(0, 20)),
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
              IDLE_FULL, IDLE_FULL, $urandom());
    settle();

    $display("Run: %0d key samples over %0d register settings, random pauses, one long stall",
             n_samples, n_settings);
    $display("Events: %0d press, %0d repeat, %0d release matched; %0d mismatches",
             kind_cnt[0], kind_cnt[1], kind_cnt[2], err_cnt);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(CLK_PERIOD * 1_000_000);
    $display("ERROR: run timed out");
    $display("*** FAILED ***");
    $finish;
  end

endmodule
